### hw/rtl/lookahead_cross_track_error_macros.svh
// ----------------------------------------------------------------------------
// Lookahead cross-track error assertion macros
// Shared helpers for concurrent checks clocked on clk and reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef LOOKAHEAD_CROSS_TRACK_ERROR_MACROS_SVH
`define LOOKAHEAD_CROSS_TRACK_ERROR_MACROS_SVH

// Same-cycle implication check.
`define LCTE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check.
`define LCTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lcte_pkg.sv
// ----------------------------------------------------------------------------
// Lookahead cross-track error package
// Constants, datapath commands and the controller-to-datapath bundle.
// ----------------------------------------------------------------------------
package lcte_pkg;

    localparam int CordicStepsDefault = 16;

    localparam logic signed [24:0] INV_GAIN      = 25'sd10187975;
    localparam logic [22:0]        LOOKAHEAD_RST = 23'd131072;
    localparam logic signed [31:0] PREV_X_RST    = 32'sd32768;
    localparam logic signed [31:0] PREV_Y_RST    = 32'sd0;

    // Multiplier sequence slots.
    localparam logic [2:0] K_WZ = 3'd0;
    localparam logic [2:0] K_XY = 3'd1;
    localparam logic [2:0] K_WW = 3'd2;
    localparam logic [2:0] K_XX = 3'd3;
    localparam logic [2:0] K_YY = 3'd4;
    localparam logic [2:0] K_ZZ = 3'd5;
    localparam logic [2:0] K_LC = 3'd6;
    localparam logic [2:0] K_PX = 3'd0;
    localparam logic [2:0] K_PY = 3'd1;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MUL,
        CMD_HINIT,
        CMD_PREROT,
        CMD_ITER,
        CMD_OFFSET,
        CMD_PMUL,
        CMD_DINIT,
        CMD_RESULT
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [2:0] k;
    } ctrl_t;

endpackage

### hw/rtl/lcte_datapath.sv
// ----------------------------------------------------------------------------
// Lookahead cross-track error datapath
// Shared multiplier, shared CORDIC vectoring stage, state and result register.
// ----------------------------------------------------------------------------
module lcte_datapath
    import lcte_pkg::*;
#(
    parameter int STEPS = CordicStepsDefault,
    localparam int IW = $clog2(STEPS)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  ctrl_t         ctrl,
    input  logic [IW-1:0] iter,
    input  logic [255:0]  in_data,
    input  logic          cfg_we,
    input  logic [22:0]   cfg_data,
    output logic [31:0]   err_data,
    output logic          deg_flag
);

    logic [22:0]        la_reg;
    logic signed [31:0] ax_reg, ay_reg, bx_reg, by_reg, px_reg, py_reg;
    logic signed [15:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [32:0] num_reg;
    logic signed [33:0] den_reg;
    logic signed [63:0] vx_reg, vy_reg, cx_reg, cy_reg;
    logic signed [32:0] tx_reg, ty_reg;
    logic               hzero_reg;
    logic [31:0]        err_reg;
    logic               deg_reg;

    logic signed [34:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [59:0] prod;
    logic signed [32:0] sum_x, sum_y;
    logic               seg_deg;
    logic signed [63:0] sh_vx, sh_vy, sh_cx, sh_cy;
    logic signed [63:0] off_x, off_y, e_full;
    logic [31:0]        e_sat;

    assign sum_x   = 33'(signed'(in_data[31:0])) + 33'(signed'(in_data[95:64]));
    assign sum_y   = 33'(signed'(in_data[63:32])) + 33'(signed'(in_data[127:96]));
    assign seg_deg = (bx_reg == ax_reg) && (by_reg == ay_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = INV_GAIN;
        if (ctrl.cmd == CMD_PMUL)
        begin
            if (ctrl.k == K_PY)
            begin
                mul_a = 35'(ty_reg) - 35'(ay_reg);
            end
            else
            begin
                mul_a = 35'(tx_reg) - 35'(ax_reg);
            end
        end
        else
        begin
            case (ctrl.k)
                K_WZ:    begin mul_a = 35'(qw_reg); mul_b = 25'(qz_reg); end
                K_XY:    begin mul_a = 35'(qx_reg); mul_b = 25'(qy_reg); end
                K_WW:    begin mul_a = 35'(qw_reg); mul_b = 25'(qw_reg); end
                K_XX:    begin mul_a = 35'(qx_reg); mul_b = 25'(qx_reg); end
                K_YY:    begin mul_a = 35'(qy_reg); mul_b = 25'(qy_reg); end
                K_ZZ:    begin mul_a = 35'(qz_reg); mul_b = 25'(qz_reg); end
                K_LC:    begin mul_a = signed'({12'b0, la_reg}); mul_b = INV_GAIN; end
                default: begin mul_a = '0; mul_b = INV_GAIN; end
            endcase
        end
    end

    assign prod  = mul_a * mul_b;
    assign sh_vx = vx_reg >>> iter;
    assign sh_vy = vy_reg >>> iter;
    assign sh_cx = cx_reg >>> iter;
    assign sh_cy = cy_reg >>> iter;
    assign off_x = hzero_reg ? signed'({41'b0, la_reg}) : (cx_reg >>> 24);
    assign off_y = hzero_reg ? 64'sd0 : (cy_reg >>> 24);
    assign e_full = cy_reg >>> 24;

    always_comb
    begin
        if (e_full > 64'sd2147483647)
        begin
            e_sat = 32'h7FFF_FFFF;
        end
        else if (e_full < -64'sd2147483648)
        begin
            e_sat = 32'h8000_0000;
        end
        else
        begin
            e_sat = e_full[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            la_reg <= LOOKAHEAD_RST;
            ax_reg <= PREV_X_RST;
            ay_reg <= PREV_Y_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                la_reg <= cfg_data;
            end
            if (ctrl.cmd == CMD_RESULT)
            begin
                ax_reg <= bx_reg;
                ay_reg <= by_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.cmd)
            CMD_LOAD:
            begin
                bx_reg <= sum_x[32:1];
                by_reg <= sum_y[32:1];
                px_reg <= in_data[159:128];
                py_reg <= in_data[191:160];
                qx_reg <= in_data[207:192];
                qy_reg <= in_data[223:208];
                qz_reg <= in_data[239:224];
                qw_reg <= in_data[255:240];
            end
            CMD_MUL:
            begin
                case (ctrl.k)
                    K_WZ:    num_reg <= 33'(prod);
                    K_XY:    num_reg <= num_reg + 33'(prod);
                    K_WW:    den_reg <= 34'(prod);
                    K_XX:    den_reg <= den_reg + 34'(prod);
                    K_YY:    den_reg <= den_reg - 34'(prod);
                    K_ZZ:    den_reg <= den_reg - 34'(prod);
                    default: cx_reg  <= 64'(prod);
                endcase
            end
            CMD_HINIT:
            begin
                hzero_reg <= (num_reg == '0) && (den_reg == '0);
                vx_reg    <= 64'(den_reg) <<< 16;
                vy_reg    <= -(64'(num_reg) <<< 17);
                cy_reg    <= '0;
            end
            CMD_PREROT:
            begin
                if (vx_reg < 0)
                begin
                    if (vy_reg >= 0)
                    begin
                        vx_reg <= vy_reg;
                        vy_reg <= -vx_reg;
                        cx_reg <= cy_reg;
                        cy_reg <= -cx_reg;
                    end
                    else
                    begin
                        vx_reg <= -vy_reg;
                        vy_reg <= vx_reg;
                        cx_reg <= -cy_reg;
                        cy_reg <= cx_reg;
                    end
                end
            end
            CMD_ITER:
            begin
                if (vy_reg >= 0)
                begin
                    vx_reg <= vx_reg + sh_vy;
                    vy_reg <= vy_reg - sh_vx;
                    cx_reg <= cx_reg + sh_cy;
                    cy_reg <= cy_reg - sh_cx;
                end
                else
                begin
                    vx_reg <= vx_reg - sh_vy;
                    vy_reg <= vy_reg + sh_vx;
                    cx_reg <= cx_reg - sh_cy;
                    cy_reg <= cy_reg + sh_cx;
                end
            end
            CMD_OFFSET:
            begin
                tx_reg <= 33'(64'(px_reg) + off_x);
                ty_reg <= 33'(64'(py_reg) + off_y);
            end
            CMD_PMUL:
            begin
                if (ctrl.k == K_PY)
                begin
                    cy_reg <= 64'(prod);
                end
                else
                begin
                    cx_reg <= 64'(prod);
                end
            end
            CMD_DINIT:
            begin
                vx_reg <= 64'(33'(bx_reg) - 33'(ax_reg)) <<< 16;
                vy_reg <= 64'(33'(by_reg) - 33'(ay_reg)) <<< 16;
            end
            CMD_RESULT:
            begin
                err_reg <= seg_deg ? 32'd0 : e_sat;
                deg_reg <= seg_deg;
            end
            default:
            begin
            end
        endcase
    end

    assign err_data = err_reg;
    assign deg_flag = deg_reg;

endmodule

### hw/rtl/lcte_ctrl.sv
// ----------------------------------------------------------------------------
// Lookahead cross-track error controller
// Sequences the datapath through heading, projection and distance phases.
// ----------------------------------------------------------------------------
module lcte_ctrl
    import lcte_pkg::*;
#(
    parameter int STEPS = CordicStepsDefault,
    localparam int IW = $clog2(STEPS)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output ctrl_t         ctrl,
    output logic [IW-1:0] iter
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_MUL    = 11'b00000000010,
        S_HINIT  = 11'b00000000100,
        S_PREH   = 11'b00000001000,
        S_ITERH  = 11'b00000010000,
        S_OFFSET = 11'b00000100000,
        S_PMUL   = 11'b00001000000,
        S_DINIT  = 11'b00010000000,
        S_PRED   = 11'b00100000000,
        S_ITERD  = 11'b01000000000,
        S_FIN    = 11'b10000000000
    } state_t;

    localparam logic [IW-1:0] IterLast = IW'(STEPS - 1);

    state_t        state_reg, state_next;
    logic [2:0]    k_reg, k_next;
    logic [IW-1:0] it_reg, it_next;
    logic          ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        it_next    = it_reg;
        ctrl.cmd   = CMD_NONE;
        ctrl.k     = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.cmd   = CMD_LOAD;
                    k_next     = K_WZ;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                ctrl.cmd = CMD_MUL;
                if (k_reg == K_LC)
                begin
                    state_next = S_HINIT;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end
            S_HINIT:
            begin
                ctrl.cmd   = CMD_HINIT;
                state_next = S_PREH;
            end
            S_PREH:
            begin
                ctrl.cmd   = CMD_PREROT;
                it_next    = '0;
                state_next = S_ITERH;
            end
            S_ITERH:
            begin
                ctrl.cmd = CMD_ITER;
                it_next  = it_reg + 1'b1;
                if (it_reg == IterLast)
                begin
                    state_next = S_OFFSET;
                end
            end
            S_OFFSET:
            begin
                ctrl.cmd   = CMD_OFFSET;
                k_next     = K_PX;
                state_next = S_PMUL;
            end
            S_PMUL:
            begin
                ctrl.cmd = CMD_PMUL;
                if (k_reg == K_PY)
                begin
                    state_next = S_DINIT;
                end
                else
                begin
                    k_next = K_PY;
                end
            end
            S_DINIT:
            begin
                ctrl.cmd   = CMD_DINIT;
                state_next = S_PRED;
            end
            S_PRED:
            begin
                ctrl.cmd   = CMD_PREROT;
                it_next    = '0;
                state_next = S_ITERD;
            end
            S_ITERD:
            begin
                ctrl.cmd = CMD_ITER;
                it_next  = it_reg + 1'b1;
                if (it_reg == IterLast)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!ov_reg || out_ready)
                begin
                    ctrl.cmd   = CMD_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (ctrl.cmd == CMD_RESULT)
        begin
            ov_next = 1'b1;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            it_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            it_reg    <= it_next;
            ov_reg    <= ov_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign iter      = it_reg;

endmodule

### hw/rtl/lookahead_cross_track_error.sv
// ----------------------------------------------------------------------------
// Lookahead cross-track error
// Signed distance of a projected lookahead point from the latest path segment.
// ----------------------------------------------------------------------------
// Each accepted word is processed to completion before the next one is taken;
// the next word can be accepted in the cycle after the result is registered.
// The work is done by the single shared CORDIC stage, which runs once for the
// heading and once for the distance, one step per cycle, plus the shared
// multiplier for the quaternion terms, the scaled lookahead distance and the
// projected point, and six setup steps. The result waits in an output
// register while the next word is processed; a result that is still waiting
// holds the block in its last step.
`include "lookahead_cross_track_error_macros.svh"

module lookahead_cross_track_error
    import lcte_pkg::*;
#(
    parameter int CORDIC_STEPS = CordicStepsDefault
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // left_cone_x, left_cone_y, right_cone_x, right_cone_y, pose_x, pose_y,
    // quat_x, quat_y, quat_z, quat_w
    input  logic [255:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // cross_track_error
    output logic [31:0]  m_tdata,
    // segment_degenerate
    output logic         m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [22:0]  cfg_data
);

    localparam int IW = $clog2(CORDIC_STEPS);

    ctrl_t         ctrl;
    logic [IW-1:0] iter;

    assign cfg_ready = 1'b1;

    lcte_ctrl #(.STEPS(CORDIC_STEPS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .ctrl      (ctrl),
        .iter      (iter)
    );

    lcte_datapath #(.STEPS(CORDIC_STEPS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .iter     (iter),
        .in_data  (s_tdata),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .err_data (m_tdata),
        .deg_flag (m_tuser)
    );

    `LCTE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
    `LCTE_ASSERT_NOW(a_deg_zero, m_tvalid && m_tuser, m_tdata == 32'd0, "degenerate with nonzero")

endmodule

### tb/lookahead_cross_track_error_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lookahead cross-track error testbench
// Drives cone pairs and poses through the stream ports, predicts the saturated
// cross-track error and degenerate flag for every accepted word, and checks
// every result word in order under random idling on both sides.
// ----------------------------------------------------------------------------

class cte_scoreboard;
    localparam longint InvGain = 10187975;

    longint prev_x;
    longint prev_y;
    longint lookahead;
    logic [31:0] err_q[$];
    logic        degen_q[$];
    int          errors;

    function new();
        prev_x = 32768;
        prev_y = 0;
        lookahead = 131072;
        errors = 0;
    endfunction

    function void set_lookahead(logic [22:0] v);
        lookahead = v;
    endfunction

    function void rotate_onto_x(inout longint vx, inout longint vy,
                                inout longint cx, inout longint cy);
        longint t;
        longint ax;
        longint ay;
        longint bx;
        longint by;
        if (vx < 0) begin
            if (vy >= 0) begin
                t = vx; vx = vy; vy = -t;
                t = cx; cx = cy; cy = -t;
            end
            else begin
                t = vx; vx = -vy; vy = t;
                t = cx; cx = -cy; cy = t;
            end
        end
        for (int i = 0; i < 16; i++) begin
            ax = vx >>> i; ay = vy >>> i;
            bx = cx >>> i; by = cy >>> i;
            if (vy >= 0) begin
                vx += ay; vy -= ax; cx += by; cy -= bx;
            end
            else begin
                vx -= ay; vy += ax; cx -= by; cy += bx;
            end
        end
    endfunction

    function void note_word(logic [255:0] d);
        longint lx, ly, rx, ry, px, py, qx, qy, qz, qw;
        longint bx, by, num, den, offx, offy, vx, vy, cx, cy, e;
        logic dg;
        lx = $signed(d[31:0]);    ly = $signed(d[63:32]);
        rx = $signed(d[95:64]);   ry = $signed(d[127:96]);
        px = $signed(d[159:128]); py = $signed(d[191:160]);
        qx = $signed(d[207:192]); qy = $signed(d[223:208]);
        qz = $signed(d[239:224]); qw = $signed(d[255:240]);
        bx = (lx + rx) >>> 1;
        by = (ly + ry) >>> 1;
        num = 2 * (qw * qz + qx * qy);
        den = qw * qw + qx * qx - qy * qy - qz * qz;
        if (num == 0 && den == 0) begin
            offx = lookahead;
            offy = 0;
        end
        else begin
            vx = den * 65536; vy = -num * 65536;
            cx = lookahead * InvGain; cy = 0;
            rotate_onto_x(vx, vy, cx, cy);
            offx = cx >>> 24;
            offy = cy >>> 24;
        end
        e = 0;
        dg = 1'b0;
        if (bx == prev_x && by == prev_y) begin
            dg = 1'b1;
        end
        else begin
            vx = (bx - prev_x) * 65536; vy = (by - prev_y) * 65536;
            cx = (px + offx - prev_x) * InvGain;
            cy = (py + offy - prev_y) * InvGain;
            rotate_onto_x(vx, vy, cx, cy);
            e = cy >>> 24;
            if (e > 64'sd2147483647) e = 64'sd2147483647;
            if (e < -64'sd2147483648) e = -64'sd2147483648;
        end
        prev_x = bx;
        prev_y = by;
        err_q = {err_q, e[31:0]};
        degen_q = {degen_q, dg};
    endfunction

    function void check_word(logic [31:0] err, logic degen);
        logic [31:0] e;
        logic dg;
        if (err_q.size() == 0) begin
            report("result word with nothing expected");
            return;
        end
        e = err_q.pop_front();
        dg = degen_q.pop_front();
        if (err !== e)
            report($sformatf("cross_track_error got %0d expected %0d",
                             $signed(err), $signed(e)));
        if (degen !== dg)
            report($sformatf("segment_degenerate got %0b expected %0b", degen, dg));
    endfunction

    function void report(string msg);
        errors++;
        if (errors <= 40)
            $display("mismatch: %s", msg);
    endfunction
endclass

module lookahead_cross_track_error_tb;
    import lcte_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [255:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic         m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [22:0]  cfg_data;

    cte_scoreboard board;
    bit calm;
    int cones_sent;

    lookahead_cross_track_error u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("FAIL lookahead_cross_track_error");
        $finish;
    end

    // Result side: random stall bursts, none once the run turns calm.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_word(m_tdata, m_tuser);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                gap = $urandom_range(1, 19);
                repeat (gap - 1)
                begin
                    @(posedge clk);
                end
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_word(logic [255:0] d);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 19);
            repeat (gap)
            begin
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        board.note_word(d);
        cones_sent++;
    endtask

    task automatic write_lookahead(logic [22:0] v);
        s_tvalid <= 1'b0;
        while (board.err_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (60)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        board.set_lookahead(v);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_quat();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'd0;
            3: return 16'($urandom());
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom();
            default: return $signed($urandom_range(0, 2000 * 65536)) - 1000 * 65536;
        endcase
    endfunction

    function automatic logic [255:0] rand_word();
        logic [255:0] d;
        for (int i = 0; i < 6; i++)
            d[i*32 +: 32] = rand_coord();
        for (int i = 0; i < 4; i++)
            d[192 + i*16 +: 16] = rand_quat();
        return d;
    endfunction

    initial
    begin
        logic [255:0] d;
        logic [255:0] last;
        logic [22:0] settings[5];
        board = new();
        calm = 1'b0;
        cones_sent = 0;
        last = '0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (5)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset midpoint coincident, zero quaternion, field extremes.
        send_word({16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0,
                   32'd0, 32'd0, 32'd0, 32'd65536});
        send_word({16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0,
                   32'd0, 32'd0, 32'd0, 32'd65536});
        send_word({16'sd16384, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0,
                   32'd0, 32'd0, 32'd0, 32'd0});
        send_word({16'd0, 16'sd16384, 16'd0, 16'd0, 32'd100, 32'd5,
                   32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
        send_word({16'hffff, 16'hffff, 16'hffff, 16'hffff, 32'h7fffffff, 32'h80000000,
                   32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000});
        send_word({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 32'h80000000, 32'h7fffffff,
                   32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000});
        send_word({-16'sd16384, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0,
                   32'd0, 32'd65536, 32'd0, 32'd0});
        send_word({16'd11585, 16'd11585, 16'd0, 16'd0, 32'd0, 32'd0,
                   32'h00020000, 32'h00020000, 32'h00020000, 32'h00020000});
        for (int i = 0; i < 8; i++)
            send_word(rand_word());

        settings[0] = 23'd0;
        settings[1] = 23'h7fffff;
        settings[2] = 23'd6553600;
        settings[3] = 23'd131072;
        settings[4] = 23'd1;
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph < 5)
                write_lookahead(settings[ph]);
            else
                write_lookahead(23'($urandom()));
            if (ph == 5)
                calm = 1'b1;
            for (int i = 0; i < 205; i++)
            begin
                d = rand_word();
                // Repeat the cone pair now and then for a coincident midpoint.
                if ($urandom_range(0, 9) == 0)
                    d[127:0] = last[127:0];
                last = d;
                send_word(d);
            end
        end
        s_tvalid <= 1'b0;

        while (board.err_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100)
        begin
            @(posedge clk);
        end
        if (board.errors == 0)
            $display("PASS lookahead_cross_track_error");
        else
            $display("FAIL lookahead_cross_track_error");
        $finish;
    end
endmodule
